// File: rtl/jssr_pkg.sv
package jssr_pkg;

  localparam int MAX_JOINTS = 3;
  localparam int JOINTS_DEF = 3;

  localparam int POS_W = 16;
  localparam int STEP_W = 11;
  localparam int TOL_W = 12;
  localparam int TICK_W = 11;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  typedef logic signed [POS_W-1:0] pos_t;
  typedef logic [TICK_W-1:0] tick_t;

  localparam tick_t TICK_MAX = '1;

  typedef enum logic [3:0] {
    PH_INIT   = 4'b0001,
    PH_POS    = 4'b0010,
    PH_NORMAL = 4'b0100,
    PH_ERROR  = 4'b1000
  } phase_t;

  localparam logic [1:0] MODE_INIT = 2'd0;
  localparam logic [1:0] MODE_POS = 2'd1;
  localparam logic [1:0] MODE_NORMAL = 2'd2;
  localparam logic [1:0] MODE_ERROR = 2'd3;

  localparam logic [1:0] ACT_KEEP = 2'd0;
  localparam logic [1:0] ACT_CLEAR = 2'd1;
  localparam logic [1:0] ACT_NEW = 2'd2;

  localparam logic [1:0] SW_INIT = 2'd1;
  localparam logic [1:0] SW_RUN = 2'd2;
  localparam logic [1:0] SW_POS = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_STEP = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_0 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_1 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_2 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE = 3'd6;

  localparam logic [STEP_W-1:0] RAMP_STEP_RST = 11'd25;
  localparam logic [TOL_W-1:0] TOLERANCE_RST = 12'd205;
  localparam pos_t TARGET_0_RST = 16'sd0;
  localparam pos_t TARGET_1_RST = 16'sd0;
  localparam pos_t TARGET_2_RST = -16'sd3215;
  localparam tick_t TIMEOUT_RST = 11'd500;
  localparam tick_t SETTLE_RST = 11'd300;

  typedef struct packed {
    logic [STEP_W-1:0] ramp_step;
    logic [TOL_W-1:0] tolerance;
    pos_t [MAX_JOINTS-1:0] target;
    tick_t enable_timeout;
    tick_t settle_ticks;
  } cfg_t;

  typedef struct packed {
    logic load_meas;
    logic ramp;
  } lane_ctl_t;

  typedef struct packed {
    logic at_target;
    logic in_tol;
  } lane_stat_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [1:0] action;
    logic send;
    logic alarm;
    pos_t [MAX_JOINTS-1:0] cmd;
  } result_t;

  function automatic logic [1:0] mode_code(phase_t ph);
    logic [1:0] m;
    case (ph)
      PH_INIT: m = MODE_INIT;
      PH_POS: m = MODE_POS;
      PH_NORMAL: m = MODE_NORMAL;
      PH_ERROR: m = MODE_ERROR;
      default: m = MODE_ERROR;
    endcase
    return m;
  endfunction

endpackage

// File: rtl/jssr_if.sv
interface jssr_tick_if;
  logic valid;
  logic ready;
  logic remote_online;
  logic [1:0] switch_position;
  logic motors_ok;
  logic safety_trip;
  jssr_pkg::pos_t meas_pos_0;
  jssr_pkg::pos_t meas_pos_1;
  jssr_pkg::pos_t meas_pos_2;
  jssr_pkg::pos_t host_pos_0;
  jssr_pkg::pos_t host_pos_1;
  jssr_pkg::pos_t host_pos_2;

  modport source (
    output valid, remote_online, switch_position, motors_ok, safety_trip,
    output meas_pos_0, meas_pos_1, meas_pos_2, host_pos_0, host_pos_1, host_pos_2,
    input ready
  );

  modport sink (
    input valid, remote_online, switch_position, motors_ok, safety_trip,
    input meas_pos_0, meas_pos_1, meas_pos_2, host_pos_0, host_pos_1, host_pos_2,
    output ready
  );
endinterface

interface jssr_result_if;
  logic valid;
  logic ready;
  logic [1:0] mode;
  logic [1:0] cmd_action;
  logic send_now;
  logic alarm;
  jssr_pkg::pos_t cmd_pos_0;
  jssr_pkg::pos_t cmd_pos_1;
  jssr_pkg::pos_t cmd_pos_2;

  modport source (
    output valid, mode, cmd_action, send_now, alarm, cmd_pos_0, cmd_pos_1, cmd_pos_2,
    input ready
  );

  modport sink (
    input valid, mode, cmd_action, send_now, alarm, cmd_pos_0, cmd_pos_1, cmd_pos_2,
    output ready
  );
endinterface

// File: rtl/joint_startup_supervisor_ramp_unit.sv
// Channel | Dir | Handshake     | Word
// tick    | in  | valid / ready | link, switch, motor flags, 3 measured, 3 host positions
// result  | out | valid / ready | mode, action, send, alarm, 3 commanded positions
// cfg     | in  | cfg_en        | register index and data, write only
//
// One word is taken per clock cycle while the skid register is empty; the mode
// logic and up to three joint lanes settle in that cycle; the result is registered.
// An output register plus a one-word skid register carry stalls, so ready
// depends only on whether the skid register is full.
// Synchronous active-high reset clears the mode, timer, setpoints and buffer valid
// flags and loads the register defaults.
module joint_startup_supervisor_ramp_unit #(
  parameter int JOINTS = jssr_pkg::JOINTS_DEF
) (
  input  logic clk,
  input  logic rst,
  jssr_tick_if.sink     tick,
  jssr_result_if.source result,
  input  logic                             cfg_en,
  input  logic [jssr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [jssr_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import jssr_pkg::*;

  cfg_t cfg;
  logic accept;
  lane_ctl_t ctl;
  result_t res;
  result_t out_buf;
  result_t skid_buf;
  logic out_valid;
  logic skid_valid;
  pos_t [MAX_JOINTS-1:0] meas;
  pos_t [MAX_JOINTS-1:0] host;
  pos_t [MAX_JOINTS-1:0] ramp;
  lane_stat_t [MAX_JOINTS-1:0] stat;

  assign meas = {tick.meas_pos_2, tick.meas_pos_1, tick.meas_pos_0};
  assign host = {tick.host_pos_2, tick.host_pos_1, tick.host_pos_0};

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ramp_step <= RAMP_STEP_RST;
      cfg.tolerance <= TOLERANCE_RST;
      cfg.target <= {TARGET_2_RST, TARGET_1_RST, TARGET_0_RST};
      cfg.enable_timeout <= TIMEOUT_RST;
      cfg.settle_ticks <= SETTLE_RST;
    end else if (cfg_en) begin
      case (cfg_index)
        CFG_RAMP_STEP: cfg.ramp_step <= cfg_data[STEP_W-1:0];
        CFG_TOLERANCE: cfg.tolerance <= cfg_data[TOL_W-1:0];
        CFG_TARGET_0: cfg.target[0] <= cfg_data;
        CFG_TARGET_1: cfg.target[1] <= cfg_data;
        CFG_TARGET_2: cfg.target[2] <= cfg_data;
        CFG_TIMEOUT: cfg.enable_timeout <= cfg_data[TICK_W-1:0];
        CFG_SETTLE: cfg.settle_ticks <= cfg_data[TICK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign tick.ready = !skid_valid;
  assign accept = tick.valid && !skid_valid;

  for (genvar j = 0; j < MAX_JOINTS; j++) begin : g_lane
    if (j < JOINTS) begin : g_on
      jssr_lane u_lane (
        .clk      (clk),
        .rst      (rst),
        .en       (accept),
        .ctl      (ctl),
        .step     (cfg.ramp_step),
        .tol      (cfg.tolerance),
        .target   (cfg.target[j]),
        .meas     (meas[j]),
        .ramp_pos (ramp[j]),
        .stat     (stat[j])
      );
    end else begin : g_off
      assign ramp[j] = '0;
      assign stat[j] = '1;
    end
  end

  jssr_ctrl #(
    .JOINTS (JOINTS)
  ) u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .en              (accept),
    .cfg             (cfg),
    .remote_online   (tick.remote_online),
    .switch_position (tick.switch_position),
    .motors_ok       (tick.motors_ok),
    .safety_trip     (tick.safety_trip),
    .host            (host),
    .ramp            (ramp),
    .stat            (stat),
    .ctl             (ctl),
    .res             (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || result.ready) begin
      if (skid_valid) begin
        out_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || result.ready) begin
      if (skid_valid) begin
        out_buf <= skid_buf;
      end else if (accept) begin
        out_buf <= res;
      end
    end else if (accept) begin
      skid_buf <= res;
    end
  end

  assign result.valid = out_valid;
  assign result.mode = out_buf.mode;
  assign result.cmd_action = out_buf.action;
  assign result.send_now = out_buf.send;
  assign result.alarm = out_buf.alarm;
  assign result.cmd_pos_0 = out_buf.cmd[0];
  assign result.cmd_pos_1 = out_buf.cmd[1];
  assign result.cmd_pos_2 = out_buf.cmd[2];

`ifndef SYNTHESIS
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register holds a word while the output register is empty");

  a_force_init: assert property (@(posedge clk) disable iff (rst)
    accept && (!tick.remote_online || tick.switch_position == SW_INIT)
      |-> res.mode == MODE_INIT && res.action == ACT_CLEAR && res.send)
    else $error("forced init did not produce an init clear result");

  a_cmd_zero: assert property (@(posedge clk) disable iff (rst)
    accept && res.action != ACT_NEW |-> res.cmd == '0)
    else $error("command positions nonzero without a new position");

  a_load_or_ramp: assert property (@(posedge clk) disable iff (rst)
    accept && ctl.ramp |=> $past(res.mode) == MODE_POS || $past(res.mode) == MODE_NORMAL
      || $past(res.mode) == MODE_ERROR)
    else $error("ramp step taken with an init result");
`endif

endmodule

// File: rtl/jssr_lane.sv
module jssr_lane (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  jssr_pkg::lane_ctl_t ctl,
  input  logic [jssr_pkg::STEP_W-1:0] step,
  input  logic [jssr_pkg::TOL_W-1:0]  tol,
  input  jssr_pkg::pos_t      target,
  input  jssr_pkg::pos_t      meas,
  output jssr_pkg::pos_t      ramp_pos,
  output jssr_pkg::lane_stat_t stat
);
  import jssr_pkg::*;

  pos_t setpoint;
  logic signed [POS_W:0] diff;
  logic [POS_W:0] diff_mag;
  logic signed [POS_W:0] mdiff;
  logic [POS_W:0] mdiff_mag;
  logic [POS_W:0] step_ext;

  assign step_ext = {{(POS_W+1-STEP_W){1'b0}}, step};
  assign diff = {target[POS_W-1], target} - {setpoint[POS_W-1], setpoint};
  assign diff_mag = diff[POS_W] ? 17'(-diff) : 17'(diff);

  always_comb begin
    if (diff_mag < step_ext) begin
      ramp_pos = target;
    end else if (diff[POS_W]) begin
      ramp_pos = POS_W'(setpoint - step_ext[POS_W-1:0]);
    end else begin
      ramp_pos = POS_W'(setpoint + step_ext[POS_W-1:0]);
    end
  end

  assign mdiff = {meas[POS_W-1], meas} - {target[POS_W-1], target};
  assign mdiff_mag = mdiff[POS_W] ? 17'(-mdiff) : 17'(mdiff);

  assign stat.at_target = (ramp_pos == target);
  assign stat.in_tol = (mdiff_mag <= {{(POS_W+1-TOL_W){1'b0}}, tol});

  always_ff @(posedge clk) begin
    if (rst) begin
      setpoint <= '0;
    end else if (en && ctl.load_meas) begin
      setpoint <= meas;
    end else if (en && ctl.ramp) begin
      setpoint <= ramp_pos;
    end
  end

endmodule

// File: rtl/jssr_ctrl.sv
module jssr_ctrl #(
  parameter int JOINTS = jssr_pkg::JOINTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  jssr_pkg::cfg_t       cfg,
  input  logic                 remote_online,
  input  logic [1:0]           switch_position,
  input  logic                 motors_ok,
  input  logic                 safety_trip,
  input  jssr_pkg::pos_t [jssr_pkg::MAX_JOINTS-1:0] host,
  input  jssr_pkg::pos_t [jssr_pkg::MAX_JOINTS-1:0] ramp,
  input  jssr_pkg::lane_stat_t [jssr_pkg::MAX_JOINTS-1:0] stat,
  output jssr_pkg::lane_ctl_t  ctl,
  output jssr_pkg::result_t    res
);
  import jssr_pkg::*;

  phase_t phase;
  phase_t phase_next;
  tick_t tick_count;
  tick_t tick_count_next;
  tick_t tick_inc;
  logic force_init;
  logic all_ok;
  pos_t [MAX_JOINTS-1:0] host_used;
  pos_t [MAX_JOINTS-1:0] ramp_used;

  assign force_init = !remote_online || (switch_position == SW_INIT);
  assign tick_inc = (tick_count == TICK_MAX) ? tick_count : tick_count + 1'b1;

  // The merge across lanes: every active joint must sit on its target and
  // read back within tolerance.
  always_comb begin
    all_ok = 1'b1;
    for (int j = 0; j < MAX_JOINTS; j++) begin
      if (j < JOINTS) begin
        host_used[j] = host[j];
        ramp_used[j] = ramp[j];
        all_ok = all_ok & stat[j].at_target & stat[j].in_tol;
      end else begin
        host_used[j] = '0;
        ramp_used[j] = '0;
      end
    end
  end

  always_comb begin
    phase_next = phase;
    tick_count_next = tick_count;
    ctl = '0;
    res.action = ACT_KEEP;
    res.send = 1'b1;
    res.alarm = 1'b0;
    res.cmd = '0;
    if (force_init) begin
      phase_next = PH_INIT;
      tick_count_next = '0;
      ctl.load_meas = 1'b1;
      res.action = ACT_CLEAR;
    end else begin
      case (phase)
        PH_INIT: begin
          if (motors_ok && (switch_position == SW_RUN || switch_position == SW_POS)) begin
            ctl.load_meas = 1'b1;
            phase_next = PH_POS;
            tick_count_next = '0;
          end else begin
            tick_count_next = tick_inc;
            if (tick_inc > cfg.enable_timeout) begin
              phase_next = PH_ERROR;
            end
          end
        end
        PH_POS: begin
          ctl.ramp = 1'b1;
          res.action = ACT_NEW;
          res.cmd = ramp_used;
          tick_count_next = tick_inc;
          if (tick_inc > cfg.settle_ticks) begin
            if (!all_ok) begin
              phase_next = PH_ERROR;
            end else if (switch_position == SW_RUN) begin
              phase_next = PH_NORMAL;
              tick_count_next = '0;
            end
          end
        end
        PH_NORMAL: begin
          if (!motors_ok) begin
            res.action = ACT_CLEAR;
            res.send = 1'b0;
          end else if (safety_trip) begin
            res.alarm = 1'b1;
            res.send = 1'b0;
          end else begin
            res.action = ACT_NEW;
            res.cmd = host_used;
          end
        end
        PH_ERROR: begin
          res.action = ACT_CLEAR;
          res.alarm = 1'b1;
        end
        default: begin
          phase_next = PH_ERROR;
          res.action = ACT_CLEAR;
          res.alarm = 1'b1;
        end
      endcase
    end
    res.mode = mode_code(phase_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_INIT;
      tick_count <= '0;
    end else if (en) begin
      phase <= phase_next;
      tick_count <= tick_count_next;
    end
  end

endmodule
